// File: rtl/gauge_curve_value_to_angle_top_macros.svh
// Assertion macros for the gauge curve RTL.
`ifndef GAUGE_CURVE_VALUE_TO_ANGLE_TOP_MACROS_SVH
`define GAUGE_CURVE_VALUE_TO_ANGLE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCVA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCVA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gcva_pkg.sv
// Shared types, constants and defaults for the gauge curve value to angle block.
package gcva_pkg;

    localparam int CURVE_TYPES_DEF     = 5;
    localparam int POINTS_DEF          = 5;
    localparam int VALUE_FRAC_BITS_DEF = 8;

    localparam int VALUE_W = 32;
    localparam int ANGLE_W = 11;
    localparam int TYPE_W  = 3;
    localparam int INDEX_W = 3;
    localparam int MAG_W   = VALUE_W + 1;
    localparam int PROD_W  = MAG_W + ANGLE_W;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    typedef enum logic [2:0] {
        STAT_INTERP  = 3'd0,
        STAT_BELOW   = 3'd1,
        STAT_ABOVE   = 3'd2,
        STAT_FLAT    = 3'd3,
        STAT_INVALID = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [ANGLE_W-1:0] ang;
    } point_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic               start;
        logic [MAG_W-1:0]   num;
        logic [ANGLE_W-1:0] mult;
        logic [MAG_W-1:0]   den;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] quo;
    } md_rsp_t;

endpackage

// File: rtl/gcva_mem.sv
// Calibration point memory: one write port, one registered read port.
module gcva_mem
    import gcva_pkg::*;
#(
    parameter int DEPTH  = CURVE_TYPES_DEF * 2 * POINTS_DEF,
    parameter int ADDR_W = $clog2(CURVE_TYPES_DEF * 2 * POINTS_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  point_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output point_t            rdata
);

    point_t mem [DEPTH];
    point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gcva_md.sv
// Multiply then restoring divide unit: quotient of num * mult / den, one bit per cycle.
module gcva_md
    import gcva_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    localparam int CNT_W = $clog2(ANGLE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ANGLE_W - 1);

    md_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [MAG_W-1:0]   num_reg, num_next;
    logic [ANGLE_W-1:0] mult_reg, mult_next;
    logic [MAG_W-1:0]   den_reg, den_next;
    logic [MAG_W-1:0]   rem_reg, rem_next;
    logic [ANGLE_W-1:0] low_reg, low_next;

    logic [PROD_W-1:0]  prod;
    logic [MAG_W:0]     trial;
    logic               ge;

    assign prod  = PROD_W'(num_reg) * PROD_W'(mult_reg);
    assign trial = {rem_reg, low_reg[ANGLE_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        mult_next  = mult_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = req.num;
                    mult_next  = req.mult;
                    den_next   = req.den;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                // The quotient never exceeds mult, so the high part already sits below den.
                {rem_next, low_next} = prod;
                cnt_next   = '0;
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                rem_next = ge ? MAG_W'(trial - {1'b0, den_reg}) : MAG_W'(trial);
                low_next = {low_reg[ANGLE_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        mult_reg <= mult_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = low_reg;

endmodule

// File: rtl/gcva_ctrl.sv
// Request sequencer: point loads, segment scan over the memory and the result register.
`include "gauge_curve_value_to_angle_top_macros.svh"

module gcva_ctrl
    import gcva_pkg::*;
#(
    parameter int CURVE_TYPES     = CURVE_TYPES_DEF,
    parameter int POINTS          = POINTS_DEF,
    parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF,
    parameter int ADDR_W          = $clog2(CURVE_TYPES_DEF * 2 * POINTS_DEF)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      mode,
    input  logic [TYPE_W-1:0]         curve_type,
    input  logic                      position,
    input  logic [INDEX_W-1:0]        point_index,
    input  logic signed [VALUE_W-1:0] point_value,
    input  logic signed [ANGLE_W-1:0] point_angle,
    input  logic signed [VALUE_W-1:0] measured_value,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic signed [ANGLE_W-1:0] angle,
    output logic [2:0]                status,
    output logic                      mem_we,
    output logic [ADDR_W-1:0]         mem_waddr,
    output point_t                    mem_wdata,
    output logic                      mem_re,
    output logic [ADDR_W-1:0]         mem_raddr,
    input  point_t                    mem_rdata,
    output md_req_t                   md_req,
    input  md_rsp_t                   md_rsp
);

    localparam int K_W = $clog2(POINTS);
    localparam logic [K_W-1:0] K_LAST = K_W'(POINTS - 1);
    // A span below this count of value steps is narrower than 0.001 and counts as flat.
    localparam int FLAT_LIMIT = (2 ** VALUE_FRAC_BITS + 999) / 1000;

    ctrl_state_t               state_reg, state_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic [ADDR_W-1:0]         base_reg, base_next;
    logic signed [VALUE_W-1:0] x_reg, x_next;
    point_t                    prev_reg, prev_next;
    point_t                    first_reg, first_next;
    logic signed [ANGLE_W-1:0] a1_reg, a1_next;
    logic                      desc_reg, desc_next;
    logic signed [ANGLE_W-1:0] res_angle_reg, res_angle_next;
    status_t                   res_status_reg, res_status_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [ANGLE_W-1:0] out_angle_reg, out_angle_next;
    status_t                   out_status_reg, out_status_next;

    logic                      req_accept;
    logic                      type_ok;
    logic                      idx_ok;
    logic [ADDR_W-1:0]         req_base;
    logic                      rising;
    logic                      in_seg;
    logic                      flat;
    logic                      desc;
    logic [MAG_W-1:0]          dv;
    logic [MAG_W-1:0]          dx;
    logic [ANGLE_W:0]          da;
    logic [MAG_W-1:0]          den_mag;
    logic [MAG_W-1:0]          num_mag;
    logic [ANGLE_W-1:0]        ang_mag;
    logic [ANGLE_W:0]          a1_ext;
    logic [ANGLE_W:0]          q_ext;
    logic                      emit_go;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign type_ok    = int'(curve_type) < CURVE_TYPES;
    assign idx_ok     = int'(point_index) < POINTS;
    assign req_base   = ADDR_W'(int'({curve_type, position}) * POINTS);

    assign mem_we          = req_accept && (mode == MODE_LOAD) && type_ok && idx_ok;
    assign mem_waddr       = ADDR_W'(int'({curve_type, position}) * POINTS + int'(point_index));
    assign mem_wdata.value = point_value;
    assign mem_wdata.ang   = point_angle;
    assign mem_raddr       = base_reg + ADDR_W'(k_reg);

    // Segment test between the held left point and the point just read.
    assign rising  = prev_reg.value <= mem_rdata.value;
    assign in_seg  = rising ? (x_reg >= prev_reg.value && x_reg <= mem_rdata.value)
                            : (x_reg >= mem_rdata.value && x_reg <= prev_reg.value);
    assign dv      = {mem_rdata.value[VALUE_W-1], mem_rdata.value}
                   - {prev_reg.value[VALUE_W-1], prev_reg.value};
    assign dx      = {x_reg[VALUE_W-1], x_reg} - {prev_reg.value[VALUE_W-1], prev_reg.value};
    assign den_mag = rising ? dv : MAG_W'(-dv);
    assign num_mag = (x_reg >= prev_reg.value) ? dx : MAG_W'(-dx);
    assign flat    = den_mag < MAG_W'(FLAT_LIMIT);
    assign desc    = mem_rdata.ang < prev_reg.ang;
    assign da      = {mem_rdata.ang[ANGLE_W-1], mem_rdata.ang}
                   - {prev_reg.ang[ANGLE_W-1], prev_reg.ang};
    assign ang_mag = desc ? ANGLE_W'(-da) : ANGLE_W'(da);

    assign a1_ext = {a1_reg[ANGLE_W-1], a1_reg};
    assign q_ext  = {1'b0, md_rsp.quo};

    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || !res_stall);

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        x_next          = x_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        a1_next         = a1_reg;
        desc_next       = desc_reg;
        res_angle_next  = res_angle_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && res_stall;
        out_angle_next  = out_angle_reg;
        out_status_next = out_status_reg;
        mem_re          = 1'b0;
        md_req          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (mode == MODE_CONVERT))
                begin
                    x_next    = measured_value;
                    base_next = req_base;
                    k_next    = '0;
                    if (type_ok)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        res_angle_next  = '0;
                        res_status_next = STAT_INVALID;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_FETCH:
            begin
                mem_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                prev_next = mem_rdata;
                if (k_reg == '0)
                begin
                    first_next = mem_rdata;
                    k_next     = k_reg + K_W'(1);
                    state_next = ST_FETCH;
                end
                else if (in_seg)
                begin
                    a1_next   = prev_reg.ang;
                    desc_next = desc;
                    if (flat)
                    begin
                        res_angle_next  = prev_reg.ang;
                        res_status_next = STAT_FLAT;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        md_req.start = 1'b1;
                        md_req.num   = num_mag;
                        md_req.mult  = ang_mag;
                        md_req.den   = den_mag;
                        state_next   = ST_DIV;
                    end
                end
                else if (k_reg == K_LAST)
                begin
                    if (x_reg < first_reg.value)
                    begin
                        res_angle_next  = first_reg.ang;
                        res_status_next = STAT_BELOW;
                    end
                    else
                    begin
                        res_angle_next  = mem_rdata.ang;
                        res_status_next = STAT_ABOVE;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_DIV:
            begin
                if (md_rsp.done)
                begin
                    res_angle_next  = ANGLE_W'(desc_reg ? a1_ext - q_ext : a1_ext + q_ext);
                    res_status_next = STAT_INTERP;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next  = 1'b1;
                    out_angle_next  = res_angle_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        x_reg          <= x_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        a1_reg         <= a1_next;
        desc_reg       <= desc_next;
        res_angle_reg  <= res_angle_next;
        res_status_reg <= res_status_next;
        out_angle_reg  <= out_angle_next;
        out_status_reg <= out_status_next;
    end

    assign res_valid = out_valid_reg;
    assign angle     = out_angle_reg;
    assign status    = out_status_reg;

    `GCVA_ASSERT_SAME(a_div_done_in_div, md_rsp.done, state_reg == ST_DIV, "divider done outside wait")
    `GCVA_ASSERT_SAME(a_k_in_range, state_reg != ST_IDLE, k_reg <= K_LAST, "point counter out of range")
    `GCVA_ASSERT_NEXT(a_emit_loads, emit_go, out_valid_reg && state_reg == ST_IDLE, "emit missed")

endmodule

// File: rtl/gauge_curve_value_to_angle_top.sv
// Top level of the gauge curve value to angle block.
//
// Request channel (req_valid / req_stall): a request with mode 0 writes one
// calibration point (value and angle) of the curve chosen by curve_type and
// position if curve_type and point_index are in range; it returns nothing and
// the next request is taken in the next cycle. A request with mode 1 converts
// measured_value through the chosen curve and returns one result (angle,
// status) on res_valid / res_stall. One conversion is worked on at a time:
// the sequencer reads the curve's points from the point memory one at a time,
// each through a fetch and a check state; for an interpolated result a
// multiplier and a one-bit-per-cycle divider then compute the angle offset.
// req_stall is high while a conversion runs. The result register lets a new
// request in while an older result waits; a stalled receiver holds the
// result, and a following result waits in the sequencer. Reset clears the
// control state only: the point memory is not cleared and each point must be
// loaded before it is read.
module gauge_curve_value_to_angle_top
    import gcva_pkg::*;
#(
    parameter int CURVE_TYPES     = CURVE_TYPES_DEF,
    parameter int POINTS          = POINTS_DEF,
    parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      mode,
    input  logic [TYPE_W-1:0]         curve_type,
    input  logic                      position,
    input  logic [INDEX_W-1:0]        point_index,
    input  logic signed [VALUE_W-1:0] point_value,
    input  logic signed [ANGLE_W-1:0] point_angle,
    input  logic signed [VALUE_W-1:0] measured_value,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic signed [ANGLE_W-1:0] angle,
    output logic [2:0]                status
);

    localparam int DEPTH  = CURVE_TYPES * 2 * POINTS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    point_t            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    point_t            mem_rdata;
    md_req_t           md_req;
    md_rsp_t           md_rsp;

    gcva_ctrl #(
        .CURVE_TYPES     (CURVE_TYPES),
        .POINTS          (POINTS),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
        .ADDR_W          (ADDR_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .mode           (mode),
        .curve_type     (curve_type),
        .position       (position),
        .point_index    (point_index),
        .point_value    (point_value),
        .point_angle    (point_angle),
        .measured_value (measured_value),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .angle          (angle),
        .status         (status),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .md_req         (md_req),
        .md_rsp         (md_rsp)
    );

    gcva_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gcva_md u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

endmodule
